FILE: rtl/mvmm_pkg.sv
// Shared types and constants for the motion vector magnitude map.
`default_nettype none
package mvmm_pkg;

	localparam int MAX_WIDTH_DEF  = 256;
	localparam int MAX_HEIGHT_DEF = 256;
	localparam int QUEUE_DEPTH    = 2;

	localparam int MAG_W   = 24;
	localparam int FRAME_W = 9;
	// Wide enough for a clip bound of the largest map edge (4096).
	localparam int COORD_W = 13;

	localparam logic [FRAME_W-1:0] FRAME_RESET = 9'd256;

	localparam logic [1:0] KIND_BEGIN  = 2'd0;
	localparam logic [1:0] KIND_VECTOR = 2'd1;
	localparam logic [1:0] KIND_READ   = 2'd2;

	localparam logic REG_FRAME_WIDTH  = 1'b0;
	localparam logic REG_FRAME_HEIGHT = 1'b1;

	typedef enum logic [1:0] {
		OP_NOP,
		OP_CLEAR,
		OP_VECTOR,
		OP_READ
	} op_t;

	typedef struct packed {
		op_t                op;
		logic [MAG_W-1:0]   mag;
		logic [COORD_W-1:0] x0;
		logic [COORD_W-1:0] x1;
		logic [COORD_W-1:0] y0;
		logic [COORD_W-1:0] y1;
	} cmd_t;

	typedef enum logic [2:0] {
		F_IDLE,
		F_SQUARE,
		F_SUM,
		F_ROOT,
		F_DIVIDE,
		F_PUSH
	} front_state_t;

	typedef enum logic [2:0] {
		B_INIT,
		B_IDLE,
		B_CLEAR,
		B_WALK,
		B_DRAIN,
		B_READ,
		B_RDATA
	} back_state_t;

endpackage
`default_nettype wire

FILE: rtl/mvmm_front.sv
// Front end: accepts items, clips blocks and works out the vector magnitude over vec_div.
`default_nettype none
module mvmm_front #(
	parameter int MAX_WIDTH  = mvmm_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = mvmm_pkg::MAX_HEIGHT_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire logic [1:0]                        kind,
	input  wire logic signed [15:0]                vec_dx,
	input  wire logic signed [15:0]                vec_dy,
	input  wire logic [15:0]                       vec_div,
	input  wire logic signed [15:0]                block_x,
	input  wire logic signed [15:0]                block_y,
	input  wire logic [7:0]                        block_w,
	input  wire logic [7:0]                        block_h,
	input  wire logic [7:0]                        read_x,
	input  wire logic [7:0]                        read_y,
	input  wire logic [mvmm_pkg::FRAME_W-1:0]      frame_width,
	input  wire logic [mvmm_pkg::FRAME_W-1:0]      frame_height,
	input  wire logic                              init_done,
	output logic                                   cmd_valid,
	input  wire logic                              cmd_ready,
	output mvmm_pkg::cmd_t                         cmd
);

	localparam int CW = mvmm_pkg::COORD_W;

	mvmm_pkg::front_state_t state_q, state_d;

	logic [CW-1:0]        w_eff, h_eff;
	logic signed [17:0]   bx_e, by_e, bend_x, bend_y, w_s, h_s;
	logic signed [17:0]   x0_c, x1_c, y0_c, y1_c;
	logic                 clip_ok, in_map, accept;
	logic [15:0]          abs_x, abs_y;

	logic [15:0]          ax_q, ay_q, scale_q;
	logic [31:0]          px_q, py_q;
	logic [47:0]          rad_q;
	logic [25:0]          rem_q, rem_n, trial;
	logic [23:0]          root_q;
	logic [16:0]          drem_q, dr;
	logic [4:0]           cnt_q;
	mvmm_pkg::cmd_t       cmd_q;

	always_comb begin
		w_eff = (CW'(frame_width) < CW'(MAX_WIDTH)) ? CW'(frame_width) : CW'(MAX_WIDTH);
		h_eff = (CW'(frame_height) < CW'(MAX_HEIGHT)) ? CW'(frame_height) : CW'(MAX_HEIGHT);
		w_s = $signed(18'(w_eff));
		h_s = $signed(18'(h_eff));
		bx_e = $signed({{2{block_x[15]}}, block_x});
		by_e = $signed({{2{block_y[15]}}, block_y});
		bend_x = bx_e + $signed(18'(block_w));
		bend_y = by_e + $signed(18'(block_h));
		x0_c = (bx_e > 18'sd0) ? bx_e : 18'sd0;
		y0_c = (by_e > 18'sd0) ? by_e : 18'sd0;
		x1_c = (bend_x < w_s) ? bend_x : w_s;
		y1_c = (bend_y < h_s) ? bend_y : h_s;
		clip_ok = (x1_c > x0_c) && (y1_c > y0_c);
		in_map = (CW'(read_x) < CW'(MAX_WIDTH)) && (CW'(read_y) < CW'(MAX_HEIGHT));
		abs_x = vec_dx[15] ? 16'(~vec_dx + 16'sd1) : vec_dx;
		abs_y = vec_dy[15] ? 16'(~vec_dy + 16'sd1) : vec_dy;
		rem_n = {rem_q[23:0], rad_q[47:46]};
		trial = {root_q, 2'b01};
		dr = {drem_q[15:0], root_q[23]};
	end

	always_comb begin
		state_d = state_q;
		in_ready = (state_q == mvmm_pkg::F_IDLE) && init_done;
		cmd_valid = (state_q == mvmm_pkg::F_PUSH);
		accept = in_valid && in_ready;
		cmd = cmd_q;
		cmd.mag = root_q;
		case (state_q)
			mvmm_pkg::F_IDLE: begin
				if (accept) begin
					if (kind == mvmm_pkg::KIND_VECTOR && vec_div != 16'd0 && clip_ok)
						state_d = mvmm_pkg::F_SQUARE;
					else
						state_d = mvmm_pkg::F_PUSH;
				end
			end
			mvmm_pkg::F_SQUARE: state_d = mvmm_pkg::F_SUM;
			mvmm_pkg::F_SUM:    state_d = mvmm_pkg::F_ROOT;
			mvmm_pkg::F_ROOT: begin
				if (cnt_q == 5'd0)
					state_d = mvmm_pkg::F_DIVIDE;
			end
			mvmm_pkg::F_DIVIDE: begin
				if (cnt_q == 5'd0)
					state_d = mvmm_pkg::F_PUSH;
			end
			mvmm_pkg::F_PUSH: begin
				if (cmd_ready)
					state_d = mvmm_pkg::F_IDLE;
			end
			default: state_d = mvmm_pkg::F_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= mvmm_pkg::F_IDLE;
		else
			state_q <= state_d;
	end

	always_ff @(posedge clk) begin
		case (state_q)
			mvmm_pkg::F_IDLE: begin
				if (accept) begin
					ax_q <= abs_x;
					ay_q <= abs_y;
					scale_q <= vec_div;
					cmd_q.mag <= '0;
					case (kind)
						mvmm_pkg::KIND_BEGIN: begin
							cmd_q.op <= mvmm_pkg::OP_CLEAR;
						end
						mvmm_pkg::KIND_VECTOR: begin
							cmd_q.op <= (vec_div != 16'd0 && clip_ok) ?
								mvmm_pkg::OP_VECTOR : mvmm_pkg::OP_NOP;
						end
						mvmm_pkg::KIND_READ: begin
							cmd_q.op <= in_map ? mvmm_pkg::OP_READ : mvmm_pkg::OP_NOP;
						end
						default: cmd_q.op <= mvmm_pkg::OP_NOP;
					endcase
					if (kind == mvmm_pkg::KIND_READ) begin
						cmd_q.x0 <= CW'(read_x);
						cmd_q.y0 <= CW'(read_y);
					end else begin
						cmd_q.x0 <= x0_c[CW-1:0];
						cmd_q.y0 <= y0_c[CW-1:0];
					end
					cmd_q.x1 <= x1_c[CW-1:0];
					cmd_q.y1 <= y1_c[CW-1:0];
				end
			end
			mvmm_pkg::F_SQUARE: begin
				px_q <= 32'(ax_q) * 32'(ax_q);
				py_q <= 32'(ay_q) * 32'(ay_q);
			end
			mvmm_pkg::F_SUM: begin
				rad_q <= {px_q + py_q, 16'd0};
				rem_q <= '0;
				root_q <= '0;
				cnt_q <= 5'd23;
			end
			mvmm_pkg::F_ROOT: begin
				// one result bit per cycle, two radicand bits brought down
				if (rem_n >= trial) begin
					rem_q <= rem_n - trial;
					root_q <= {root_q[22:0], 1'b1};
				end else begin
					rem_q <= rem_n;
					root_q <= {root_q[22:0], 1'b0};
				end
				rad_q <= {rad_q[45:0], 2'b00};
				drem_q <= '0;
				cnt_q <= (cnt_q == 5'd0) ? 5'd23 : cnt_q - 5'd1;
			end
			mvmm_pkg::F_DIVIDE: begin
				// restoring division, quotient shifts in behind the dividend
				if (dr >= {1'b0, scale_q}) begin
					drem_q <= dr - {1'b0, scale_q};
					root_q <= {root_q[22:0], 1'b1};
				end else begin
					drem_q <= dr;
					root_q <= {root_q[22:0], 1'b0};
				end
				cnt_q <= cnt_q - 5'd1;
			end
			default: ;
		endcase
	end

endmodule
`default_nettype wire

FILE: rtl/mvmm_queue.sv
// Small command queue between the front end and the map walker.
`default_nettype none
module mvmm_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = mvmm_pkg::QUEUE_DEPTH
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push_valid,
	output logic                  push_ready,
	input  wire logic [WIDTH-1:0] push_data,
	output logic                  pop_valid,
	input  wire logic             pop_ready,
	output logic [WIDTH-1:0]      pop_data
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNTW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PW-1:0]    wr_q, rd_q;
	logic [CNTW-1:0]  count_q;
	logic             do_push, do_pop;

	assign push_ready = (count_q != CNTW'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = slot_q[rd_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push)
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
			if (do_pop)
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
			if (do_push && !do_pop)
				count_q <= count_q + CNTW'(1);
			else if (do_pop && !do_push)
				count_q <= count_q - CNTW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (do_push)
			slot_q[wr_q] <= push_data;
	end

endmodule
`default_nettype wire

FILE: rtl/mvmm_back.sv
// Back end: map memory, clearing sweep, max-merge walker and result register.
`default_nettype none
module mvmm_back #(
	parameter int MAX_WIDTH  = mvmm_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = mvmm_pkg::MAX_HEIGHT_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cmd_valid,
	output logic                              cmd_ready,
	input  wire mvmm_pkg::cmd_t               cmd,
	output logic                              init_done,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic [mvmm_pkg::MAG_W-1:0]        pixel_magnitude,
	output logic                              frame_has_motion,
	output logic                              vector_applied
);

	localparam int XW = $clog2(MAX_WIDTH);
	localparam int YW = $clog2(MAX_HEIGHT);
	localparam int AW = XW + YW;
	localparam int DEPTH = 1 << AW;
	localparam int CW = mvmm_pkg::COORD_W;
	localparam int MW = mvmm_pkg::MAG_W;

	mvmm_pkg::back_state_t state_q, state_d;
	mvmm_pkg::cmd_t        cur_q;

	logic [MW-1:0] mem [DEPTH];
	logic [MW-1:0] rdata_q, wdata, res_mag;
	logic [AW-1:0] waddr, raddr, sweep_q, waddr_s1;
	logic [XW-1:0] x_q;
	logic [YW-1:0] y_q;
	logic          we, walk_v_s1, pop, done, res_flag, res_applied;
	logic          flag_q, out_valid_q, last_x, last_y;
	logic [MW-1:0] mag_q;

	assign init_done = (state_q != mvmm_pkg::B_INIT);
	assign out_valid = out_valid_q;
	assign frame_has_motion = flag_q;
	assign pixel_magnitude = mag_q;

	always_comb begin
		last_x = (CW'(x_q) + CW'(1)) == cur_q.x1;
		last_y = (CW'(y_q) + CW'(1)) == cur_q.y1;
		state_d = state_q;
		cmd_ready = (state_q == mvmm_pkg::B_IDLE) && !out_valid_q;
		pop = cmd_valid && cmd_ready;
		done = 1'b0;
		res_mag = '0;
		res_flag = flag_q;
		res_applied = 1'b0;
		raddr = {y_q, x_q};
		if (state_q == mvmm_pkg::B_INIT || state_q == mvmm_pkg::B_CLEAR) begin
			we = 1'b1;
			waddr = sweep_q;
			wdata = '0;
		end else begin
			we = walk_v_s1;
			waddr = waddr_s1;
			wdata = (rdata_q > cur_q.mag) ? rdata_q : cur_q.mag;
		end
		case (state_q)
			mvmm_pkg::B_INIT: begin
				if (&sweep_q)
					state_d = mvmm_pkg::B_IDLE;
			end
			mvmm_pkg::B_IDLE: begin
				if (pop) begin
					case (cmd.op)
						mvmm_pkg::OP_CLEAR:  state_d = mvmm_pkg::B_CLEAR;
						mvmm_pkg::OP_VECTOR: state_d = mvmm_pkg::B_WALK;
						mvmm_pkg::OP_READ:   state_d = mvmm_pkg::B_READ;
						default:             done = 1'b1;
					endcase
				end
			end
			mvmm_pkg::B_CLEAR: begin
				if (&sweep_q) begin
					state_d = mvmm_pkg::B_IDLE;
					done = 1'b1;
					res_flag = 1'b0;
				end
			end
			mvmm_pkg::B_WALK: begin
				if (last_x && last_y)
					state_d = mvmm_pkg::B_DRAIN;
			end
			mvmm_pkg::B_DRAIN: begin
				state_d = mvmm_pkg::B_IDLE;
				done = 1'b1;
				res_flag = 1'b1;
				res_applied = 1'b1;
			end
			mvmm_pkg::B_READ: state_d = mvmm_pkg::B_RDATA;
			mvmm_pkg::B_RDATA: begin
				state_d = mvmm_pkg::B_IDLE;
				done = 1'b1;
				res_mag = rdata_q;
			end
			default: state_d = mvmm_pkg::B_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mvmm_pkg::B_INIT;
			sweep_q <= '0;
			walk_v_s1 <= 1'b0;
			flag_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			walk_v_s1 <= (state_q == mvmm_pkg::B_WALK);
			if (state_q == mvmm_pkg::B_INIT || state_q == mvmm_pkg::B_CLEAR)
				sweep_q <= sweep_q + AW'(1);
			if (done) begin
				out_valid_q <= 1'b1;
				flag_q <= res_flag;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		waddr_s1 <= raddr;
		if (done) begin
			mag_q <= res_mag;
			vector_applied <= res_applied;
		end
		if (pop) begin
			cur_q <= cmd;
			x_q <= cmd.x0[XW-1:0];
			y_q <= cmd.y0[YW-1:0];
		end else if (state_q == mvmm_pkg::B_WALK) begin
			// advance along the row, wrap to the clip's left edge
			if (last_x) begin
				x_q <= cur_q.x0[XW-1:0];
				y_q <= y_q + YW'(1);
			end else begin
				x_q <= x_q + XW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata_q <= mem[raddr];
	end

	a_flag_low_in_init: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == mvmm_pkg::B_INIT |-> !flag_q)
		else $error("has-motion flag set during initial clear");

	a_pop_needs_free_slot: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready |-> !out_valid_q)
		else $error("command taken while a result is still held");

	a_merge_follows_walk: assert property (@(posedge clk) disable iff (!arst_n)
		walk_v_s1 |-> $past(state_q) == mvmm_pkg::B_WALK)
		else $error("merge write without a walker read");

	a_no_result_from_init: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) != mvmm_pkg::B_INIT)
		else $error("result produced by the reset clear");

endmodule
`default_nettype wire

FILE: rtl/motion_vector_magnitude_map_core.sv
// Top level: configuration registers, front end, command queue and map back end.
// Vector: the front squares, takes a 24-step root and a 24-step divide; then the walker
//   does one read-modify-write per covered pixel per cycle on the single map memory;
//   the slower of the two sets the sustained rate.
// Begin frame: clears all 2^(log2 MAX_WIDTH + log2 MAX_HEIGHT) map entries (65536
//   at defaults), one map entry cleared per cycle.
// Reset: the same clearing sweep runs first; in_ready stays low until it ends.
`default_nettype none
module motion_vector_magnitude_map_core #(
	parameter int MAX_WIDTH  = mvmm_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = mvmm_pkg::MAX_HEIGHT_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       psel,
	input  wire logic                       penable,
	input  wire logic                       pwrite,
	input  wire logic [2:0]                 paddr,
	input  wire logic [31:0]                pwdata,
	output logic [31:0]                     prdata,
	output logic                            pready,
	input  wire logic                       in_valid,
	output logic                            in_ready,
	input  wire logic [1:0]                 kind,
	input  wire logic signed [15:0]         vec_dx,
	input  wire logic signed [15:0]         vec_dy,
	input  wire logic [15:0]                vec_div,
	input  wire logic signed [15:0]         block_x,
	input  wire logic signed [15:0]         block_y,
	input  wire logic [7:0]                 block_w,
	input  wire logic [7:0]                 block_h,
	input  wire logic [7:0]                 read_x,
	input  wire logic [7:0]                 read_y,
	output logic                            out_valid,
	input  wire logic                       out_ready,
	output logic [mvmm_pkg::MAG_W-1:0]      pixel_magnitude,
	output logic                            frame_has_motion,
	output logic                            vector_applied
);

	localparam int FW = mvmm_pkg::FRAME_W;

	logic [FW-1:0]   frame_width_q, frame_height_q;
	logic            reg_wr, init_done;
	logic            fq_valid, fq_ready, bq_valid, bq_ready;
	mvmm_pkg::cmd_t  f_cmd, b_cmd;

	assign pready = 1'b1;
	assign reg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q <= mvmm_pkg::FRAME_RESET;
			frame_height_q <= mvmm_pkg::FRAME_RESET;
		end else if (reg_wr) begin
			case (paddr[2])
				mvmm_pkg::REG_FRAME_WIDTH:  frame_width_q <= pwdata[FW-1:0];
				mvmm_pkg::REG_FRAME_HEIGHT: frame_height_q <= pwdata[FW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			mvmm_pkg::REG_FRAME_WIDTH:  prdata = 32'(frame_width_q);
			mvmm_pkg::REG_FRAME_HEIGHT: prdata = 32'(frame_height_q);
			default:                    prdata = '0;
		endcase
	end

	mvmm_front #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.kind         (kind),
		.vec_dx       (vec_dx),
		.vec_dy       (vec_dy),
		.vec_div      (vec_div),
		.block_x      (block_x),
		.block_y      (block_y),
		.block_w      (block_w),
		.block_h      (block_h),
		.read_x       (read_x),
		.read_y       (read_y),
		.frame_width  (frame_width_q),
		.frame_height (frame_height_q),
		.init_done    (init_done),
		.cmd_valid    (fq_valid),
		.cmd_ready    (fq_ready),
		.cmd          (f_cmd)
	);

	mvmm_queue #(
		.WIDTH ($bits(mvmm_pkg::cmd_t)),
		.DEPTH (mvmm_pkg::QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (fq_valid),
		.push_ready (fq_ready),
		.push_data  (f_cmd),
		.pop_valid  (bq_valid),
		.pop_ready  (bq_ready),
		.pop_data   (b_cmd)
	);

	mvmm_back #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd_valid        (bq_valid),
		.cmd_ready        (bq_ready),
		.cmd              (b_cmd),
		.init_done        (init_done),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.pixel_magnitude  (pixel_magnitude),
		.frame_has_motion (frame_has_motion),
		.vector_applied   (vector_applied)
	);

endmodule
`default_nettype wire
